// File: rtl/rvmd_pkg.sv
// ----------------------------------------------------------------------------
// rvmd_pkg
// Shared types and constants of the RV32 mul/div execute unit.
// ----------------------------------------------------------------------------
package rvmd_pkg;

  localparam logic [6:0]  OP_IMM_ZEXT = 7'h13;
  localparam logic [6:0]  OP_LUI      = 7'h37;
  localparam logic [6:0]  OP_AUIPC    = 7'h17;
  localparam logic [6:0]  OP_MULDIV   = 7'h33;
  localparam logic [6:0]  F7_MULDIV   = 7'h01;
  localparam logic [2:0]  F3_ZEXT     = 3'd6;
  localparam logic [2:0]  F3_MUL      = 3'd0;
  localparam logic [2:0]  F3_MULH     = 3'd1;
  localparam logic [2:0]  F3_DIV      = 3'd4;
  localparam logic [2:0]  F3_REM      = 3'd6;
  localparam logic [31:0] UPPER_MASK  = 32'hFFFF_F000;
  localparam logic [31:0] SP_RESET    = 32'd2465792;
  localparam logic [4:0]  SP_IDX      = 5'd2;

  typedef enum logic [2:0] {
    OPK_BAD  = 3'd0,
    OPK_IMM  = 3'd1,
    OPK_ZEXT = 3'd2,
    OPK_MUL  = 3'd3,
    OPK_MULH = 3'd4,
    OPK_DIV  = 3'd5,
    OPK_REM  = 3'd6
  } opk_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch word, decode
    logic rd_rs;     // operands read from register file
    logic start;     // set up divider, zero-extend byte
    logic mul_step;  // register the product
    logic div_step;  // one divider iteration
    logic finish;    // form result, write back
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    opk_t kind;
    logic div_last;
  } sts_t;

endpackage

// File: rtl/rvmd_ctrl.sv
// ----------------------------------------------------------------------------
// rvmd_ctrl
// Sequencer: load, operand read, execute, writeback, output hold.
// ----------------------------------------------------------------------------
module rvmd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rvmd_pkg::sts_t sts,
  output rvmd_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_DONE = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_rs = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.start = 1'b1;
        if (sts.kind == rvmd_pkg::OPK_MUL || sts.kind == rvmd_pkg::OPK_MULH) begin
          state_nxt = S_MUL;
        end else if (sts.kind == rvmd_pkg::OPK_DIV || sts.kind == rvmd_pkg::OPK_REM) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: rtl/rvmd_dp.sv
// ----------------------------------------------------------------------------
// rvmd_dp
// Decode, register file, multiplier, radix-2 restoring divider, writeback.
// ----------------------------------------------------------------------------
module rvmd_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  rvmd_pkg::cmd_t cmd,
  output rvmd_pkg::sts_t sts,
  input  logic [31:0]    in_instruction,
  input  logic [31:0]    in_instr_addr,
  output logic           out_status,
  output logic           out_wrote,
  output logic [4:0]     out_dest_reg,
  output logic [31:0]    out_dest_value
);

  logic [31:0]      rf_r [32];
  logic [31:0]      ir_r, imm_r, a_r, b_r, res_r;
  rvmd_pkg::opk_t   kind_r, kind_nxt;
  logic [63:0]      prod_r;
  logic [31:0]      quo_r, rem_r, dvs_r;
  logic [5:0]       cnt_r;
  logic             qneg_r, rneg_r, dz_r, ovf_r;
  logic             status_r, wrote_r;
  logic [31:0]      dest_value_r;
  logic [4:0]       dest_reg_r;

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd;
  logic [32:0] trial;
  logic [31:0] rem_sh, val;
  logic [31:0] mag_a, mag_b;

  always_comb begin
    opc = in_instruction[6:0];
    f3  = in_instruction[14:12];
    f7  = in_instruction[31:25];
    kind_nxt = rvmd_pkg::OPK_BAD;
    if (opc == rvmd_pkg::OP_LUI || opc == rvmd_pkg::OP_AUIPC) begin
      kind_nxt = rvmd_pkg::OPK_IMM;
    end else if (opc == rvmd_pkg::OP_IMM_ZEXT && f3 == rvmd_pkg::F3_ZEXT) begin
      kind_nxt = rvmd_pkg::OPK_ZEXT;
    end else if (opc == rvmd_pkg::OP_MULDIV && f7 == rvmd_pkg::F7_MULDIV) begin
      unique case (f3)
        rvmd_pkg::F3_MUL:  kind_nxt = rvmd_pkg::OPK_MUL;
        rvmd_pkg::F3_MULH: kind_nxt = rvmd_pkg::OPK_MULH;
        rvmd_pkg::F3_DIV:  kind_nxt = rvmd_pkg::OPK_DIV;
        rvmd_pkg::F3_REM:  kind_nxt = rvmd_pkg::OPK_REM;
        default:           kind_nxt = rvmd_pkg::OPK_BAD;
      endcase
    end
  end

  assign rd      = ir_r[11:7];
  assign mag_a   = a_r[31] ? (32'd0 - a_r) : a_r;
  assign mag_b   = b_r[31] ? (32'd0 - b_r) : b_r;
  assign rem_sh  = {rem_r[30:0], quo_r[31]};
  assign trial   = {1'b0, rem_sh} - {1'b0, dvs_r};

  assign sts.kind     = kind_r;
  assign sts.div_last = (cnt_r == 6'd31);

  always_comb begin
    unique case (kind_r)
      rvmd_pkg::OPK_IMM, rvmd_pkg::OPK_ZEXT: val = imm_r;
      rvmd_pkg::OPK_MUL:  val = prod_r[31:0];
      rvmd_pkg::OPK_MULH: val = prod_r[63:32];
      rvmd_pkg::OPK_DIV: begin
        if (dz_r)        val = 32'hFFFF_FFFF;
        else if (ovf_r)  val = 32'h8000_0000;
        else if (qneg_r) val = 32'd0 - quo_r;
        else             val = quo_r;
      end
      rvmd_pkg::OPK_REM: begin
        if (dz_r)        val = a_r;
        else if (ovf_r)  val = 32'd0;
        else if (rneg_r) val = 32'd0 - rem_r;
        else             val = rem_r;
      end
      default: val = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ir_r   <= in_instruction;
      kind_r <= kind_nxt;
      imm_r  <= (opc == rvmd_pkg::OP_AUIPC)
                ? in_instr_addr + (in_instruction & rvmd_pkg::UPPER_MASK)
                : (in_instruction & rvmd_pkg::UPPER_MASK);
    end
    if (cmd.rd_rs) begin
      a_r <= (ir_r[19:15] == 5'd0) ? 32'd0 : rf_r[ir_r[19:15]];
      b_r <= (ir_r[24:20] == 5'd0) ? 32'd0 : rf_r[ir_r[24:20]];
    end
    if (cmd.start) begin
      if (kind_r == rvmd_pkg::OPK_ZEXT) imm_r <= {24'd0, a_r[7:0]};
      quo_r  <= mag_a;
      rem_r  <= 32'd0;
      dvs_r  <= mag_b;
      cnt_r  <= 6'd0;
      qneg_r <= a_r[31] ^ b_r[31];
      rneg_r <= a_r[31];
      dz_r   <= (b_r == 32'd0);
      ovf_r  <= (a_r == 32'h8000_0000) && (b_r == 32'hFFFF_FFFF);
    end
    if (cmd.mul_step) prod_r <= $signed(a_r) * $signed(b_r);
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 6'd1;
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      dest_reg_r   <= rd;
      status_r     <= (kind_r == rvmd_pkg::OPK_BAD);
      wrote_r      <= (kind_r != rvmd_pkg::OPK_BAD) && (rd != 5'd0);
      dest_value_r <= ((kind_r != rvmd_pkg::OPK_BAD) && (rd != 5'd0)) ? val : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        rf_r[i] <= (5'(i) == rvmd_pkg::SP_IDX) ? rvmd_pkg::SP_RESET : 32'd0;
      end
    end else if (cmd.finish && kind_r != rvmd_pkg::OPK_BAD && rd != 5'd0) begin
      rf_r[rd] <= val;
    end
  end

  assign out_status     = status_r;
  assign out_wrote      = wrote_r;
  assign out_dest_reg   = dest_reg_r;
  assign out_dest_value = dest_value_r;

endmodule

// File: rtl/rv32_muldiv_execute_unit_core.sv
// ----------------------------------------------------------------------------
// rv32_muldiv_execute_unit_core
// Executes one RV32 word (LUI, AUIPC, zero-extend byte, MUL/MULH/DIV/REM).
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_ready, in_instruction, in_instr_addr
//  out     | output    | out_valid, out_ready, out_status, out_wrote,
//          |           | out_dest_reg, out_dest_value
//
// One word at a time. LUI/AUIPC/zero-extend pass operand read, execute and writeback;
// MUL/MULH add a product step, DIV/REM 32 iterations of the radix-2 divider.
// Output is held until taken; the next word is accepted the cycle after.
// Reset loads the register file at once (x2 = stack pointer start).
module rv32_muldiv_execute_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_instr_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic        out_wrote,
  output logic [4:0]  out_dest_reg,
  output logic [31:0] out_dest_value
);

  rvmd_pkg::cmd_t cmd;
  rvmd_pkg::sts_t sts;

  rvmd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  rvmd_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_instruction, .in_instr_addr,
    .out_status, .out_wrote, .out_dest_reg, .out_dest_value
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");

  a_wrote_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wrote |-> !out_status && out_dest_reg != 5'd0)
    else $error("write flagged on bad or x0");

  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wrote |-> out_dest_value == 32'd0)
    else $error("nonzero value without write");

  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready) else $error("not back to idle");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives RV32 words into the mul/div execute unit with random gaps and output
// stalls, predicts each result from a local register file model and checks
// every field in order. Directed rows first, then mostly valid random words.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM   = 1350;

  typedef struct {
    logic        status;
    logic        wrote;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
  } exec_res_t;

  typedef struct {
    logic [31:0] word;
    logic [31:0] addr;
    logic        known;
    exec_res_t   res;
  } stim_row_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [31:0] in_instruction, in_instr_addr;
  logic        out_status, out_wrote;
  logic [4:0]  out_dest_reg;
  logic [31:0] out_dest_value;

  rv32_muldiv_execute_unit_core i_dut (.*);

  logic [31:0] model_regs [32];
  exec_res_t   pending_results [$];
  int          errors;
  int          idle_cycles;
  int          next_gap;
  bit          long_hold;
  bit          stim_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] rnd_reg();
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] rnd_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      3: return 32'($urandom_range(0, 20));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] rd_val(logic [4:0] idx);
    return idx == 5'd0 ? 32'd0 : model_regs[idx];
  endfunction

  function automatic exec_res_t execute_word(logic [31:0] word, logic [31:0] addr);
    exec_res_t   r;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [31:0] a, b, mag_a, mag_b, q;
    logic signed [63:0] prod;
    logic        ok;
    logic [31:0] val;
    op  = word[6:0];
    f3  = word[14:12];
    a   = rd_val(word[19:15]);
    b   = rd_val(word[24:20]);
    ok  = 1'b1;
    val = '0;
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    if (op == rvmd_pkg::OP_LUI) val = word & rvmd_pkg::UPPER_MASK;
    else if (op == rvmd_pkg::OP_AUIPC) val = addr + (word & rvmd_pkg::UPPER_MASK);
    else if (op == rvmd_pkg::OP_IMM_ZEXT && f3 == rvmd_pkg::F3_ZEXT) val = {24'd0, a[7:0]};
    else if (op == rvmd_pkg::OP_MULDIV && word[31:25] == rvmd_pkg::F7_MULDIV) begin
      case (f3)
        rvmd_pkg::F3_MUL: val = a * b;
        rvmd_pkg::F3_MULH: begin
          prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          val = prod[63:32];
        end
        rvmd_pkg::F3_DIV: begin
          if (b == 0) val = 32'hFFFF_FFFF;
          else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) val = 32'h8000_0000;
          else begin
            q = mag_a / mag_b;
            val = (a[31] ^ b[31]) ? -q : q;
          end
        end
        rvmd_pkg::F3_REM: begin
          if (b == 0) val = a;
          else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) val = 0;
          else begin
            q = mag_a % mag_b;
            val = a[31] ? -q : q;
          end
        end
        default: ok = 1'b0;
      endcase
    end else ok = 1'b0;
    r.dest_reg = word[11:7];
    r.status   = ~ok;
    r.wrote    = ok && word[11:7] != 0;
    r.dest_value = r.wrote ? val : 32'd0;
    if (r.wrote) model_regs[word[11:7]] = val;
    return r;
  endfunction

  function automatic logic [31:0] rnd_word();
    logic [2:0] f3s [4] = '{rvmd_pkg::F3_MUL, rvmd_pkg::F3_MULH,
                            rvmd_pkg::F3_DIV, rvmd_pkg::F3_REM};
    case ($urandom_range(0, 9))
      0: return {20'($urandom_range(0, 32'hFFFFF)), rnd_reg(), rvmd_pkg::OP_LUI};
      1: return {20'($urandom_range(0, 32'hFFFFF)), rnd_reg(), rvmd_pkg::OP_AUIPC};
      2: return {12'($urandom()), rnd_reg(), rvmd_pkg::F3_ZEXT, rnd_reg(),
                 rvmd_pkg::OP_IMM_ZEXT};
      3: return $urandom();
      4: return {25'($urandom()), rvmd_pkg::OP_MULDIV};
      default: return enc_r(rvmd_pkg::F7_MULDIV, rnd_reg(), rnd_reg(),
                            f3s[$urandom_range(0, 3)], rnd_reg(), rvmd_pkg::OP_MULDIV);
    endcase
  endfunction

  // called at a falling edge; valid drops after the accept unless the next gap is zero
  task automatic send_row(logic [31:0] word, logic [31:0] addr, logic known,
                          exec_res_t exp_res);
    exec_res_t pred;
    repeat (next_gap) @(negedge clk);
    in_valid       <= 1'b1;
    in_instruction <= word;
    in_instr_addr  <= addr;
    do @(posedge clk); while (!in_ready);
    pred = execute_word(word, addr);
    pending_results.push_back(known ? exp_res : pred);
    @(negedge clk);
    next_gap = $urandom_range(0, 16);
    if (next_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic send_word(logic [31:0] word, logic [31:0] addr);
    exec_res_t none;
    none = '{1'b0, 1'b0, 5'd0, 32'd0};
    send_row(word, addr, 1'b0, none);
  endtask

  task automatic idle_input();
    if (next_gap == 0) begin
      in_valid <= 1'b0;
      next_gap = 1;
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    stim_row_t rows [$];
    rst_n = 0; in_valid = 0; in_instruction = 0; in_instr_addr = 0;
    errors = 0; stim_done = 0; next_gap = 0;
    foreach (model_regs[i]) model_regs[i] = 0;
    model_regs[rvmd_pkg::SP_IDX] = rvmd_pkg::SP_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1;

    rows = '{
      '{enc_r(7'd0, 5'd0, 5'd2, rvmd_pkg::F3_ZEXT, 5'd5, rvmd_pkg::OP_IMM_ZEXT), 0, 1,
        '{0, 1, 5, 32'h00}},
      '{32'hFFFF_F000 | {5'd1, rvmd_pkg::OP_LUI}, 0, 1, '{0, 1, 1, 32'hFFFF_F000}},
      '{{20'h80000, 5'd3, rvmd_pkg::OP_LUI}, 0, 1, '{0, 1, 3, 32'h8000_0000}},
      '{{20'h00001, 5'd4, rvmd_pkg::OP_AUIPC}, 32'hFFFF_FFFF, 1,
        '{0, 1, 4, 32'h0000_0FFF}},
      '{{20'hFFFFF, 5'd0, rvmd_pkg::OP_LUI}, 0, 1, '{0, 0, 0, 0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{1, 0, 31, 0}},
      '{32'h0000_0000, 0, 1, '{1, 0, 0, 0}},
      '{enc_r(7'd0, 5'd1, 5'd3, rvmd_pkg::F3_MUL, 5'd6, rvmd_pkg::OP_MULDIV), 0, 1,
        '{1, 0, 6, 0}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd1, 5'd3, 3'd2, 5'd6, rvmd_pkg::OP_MULDIV), 0, 1,
        '{1, 0, 6, 0}},
      '{enc_r(7'd0, 5'd0, 5'd2, 3'd0, 5'd6, rvmd_pkg::OP_IMM_ZEXT), 0, 1, '{1, 0, 6, 0}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd0, 5'd3, rvmd_pkg::F3_DIV, 5'd7,
              rvmd_pkg::OP_MULDIV), 0, 1, '{0, 1, 7, 32'hFFFF_FFFF}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd0, 5'd3, rvmd_pkg::F3_REM, 5'd8,
              rvmd_pkg::OP_MULDIV), 0, 1, '{0, 1, 8, 32'h8000_0000}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd7, 5'd3, rvmd_pkg::F3_DIV, 5'd9,
              rvmd_pkg::OP_MULDIV), 0, 1, '{0, 1, 9, 32'h8000_0000}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd7, 5'd3, rvmd_pkg::F3_REM, 5'd10,
              rvmd_pkg::OP_MULDIV), 0, 1, '{0, 1, 10, 0}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd1, 5'd1, rvmd_pkg::F3_MUL, 5'd11,
              rvmd_pkg::OP_MULDIV), 0, 0, '{0, 0, 0, 0}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd3, 5'd3, rvmd_pkg::F3_MULH, 5'd12,
              rvmd_pkg::OP_MULDIV), 0, 0, '{0, 0, 0, 0}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd7, 5'd1, rvmd_pkg::F3_MULH, 5'd13,
              rvmd_pkg::OP_MULDIV), 0, 0, '{0, 0, 0, 0}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd4, 5'd2, rvmd_pkg::F3_DIV, 5'd14,
              rvmd_pkg::OP_MULDIV), 0, 0, '{0, 0, 0, 0}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd4, 5'd1, rvmd_pkg::F3_REM, 5'd15,
              rvmd_pkg::OP_MULDIV), 0, 0, '{0, 0, 0, 0}},
      '{enc_r(rvmd_pkg::F7_MULDIV, 5'd2, 5'd2, rvmd_pkg::F3_DIV, 5'd0,
              rvmd_pkg::OP_MULDIV), 0, 1, '{0, 0, 0, 0}},
      '{enc_r(7'h7F, 5'd31, 5'd1, rvmd_pkg::F3_ZEXT, 5'd16, rvmd_pkg::OP_IMM_ZEXT), 0, 0,
        '{0, 0, 0, 0}}
    };
    foreach (rows[i]) send_row(rows[i].word, rows[i].addr, rows[i].known, rows[i].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) begin
        long_hold = 1;
        while (long_hold) send_word(rnd_word(), $urandom());
      end
      if (n == 900) begin
        idle_input();
        wait_drained();
        repeat (60) @(negedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        // seed registers with edge operands through LUI
        send_word({rnd_operand() & rvmd_pkg::UPPER_MASK} |
                  {7'd0, rnd_reg(), rvmd_pkg::OP_LUI}, 0);
      end
      send_word(rnd_word(), $urandom());
    end
    idle_input();
    stim_done = 1;
  end

  initial begin
    int k;
    long_hold = 0;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end else begin
        k = $urandom_range(0, 16);
        if (k != 0) begin
          out_ready <= 1'b0;
          repeat (k) @(negedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!(out_valid && out_ready));
      end
    end
  end

  always @(posedge clk) begin
    exec_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: status %0d rd %0d value %h", $time,
                 out_status, out_dest_reg, out_dest_value);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status || out_wrote !== exp_r.wrote ||
            out_dest_reg !== exp_r.dest_reg || out_dest_value !== exp_r.dest_value) begin
          $display("%0t mismatch: expected st %0d wr %0d rd %0d val %h,",
                   $time, exp_r.status, exp_r.wrote, exp_r.dest_reg, exp_r.dest_value);
          $display("%0t   got st %0d wr %0d rd %0d val %h",
                   $time, out_status, out_wrote, out_dest_reg, out_dest_value);
          errors++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
